// ----- rtl/core/itp_pkg.sv -----
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_OVERFLOW       = 3'd1;
  localparam logic [2:0] ST_UNMATCHED_CLOSE = 3'd2;
  localparam logic [2:0] ST_MISSING_OPND   = 3'd3;
  localparam logic [2:0] ST_UNMATCHED_OPEN = 3'd4;
  localparam logic [2:0] ST_BAD_COUNT      = 3'd5;

  typedef enum logic [2:0] {
    K_OPND,
    K_OPEN,
    K_CLOSE,
    K_OPER,
    K_END
  } kind_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] sym;
    logic [1:0] prec;
  } cmd_t;

  function automatic logic [1:0] prec_of(input logic [7:0] ch);
    logic [1:0] p;
    unique case (ch)
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] ch);
    return (ch >= CH_DIG0 && ch <= CH_DIG9) || (ch >= CH_UPA && ch <= CH_UPZ) ||
           (ch >= CH_LOA && ch <= CH_LOZ);
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

endpackage

// ----- rtl/core/itp_fifo.sv -----
module itp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wptr_r;
  logic [AW:0]      rptr_r;
  logic             do_wr;
  logic             do_rd;

  assign empty = (wptr_r == rptr_r);
  assign full  = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/itp_front.sv -----
module itp_front (
  input  logic               push,
  input  itp_pkg::in_item_t  in_item,
  input  logic               q_full,
  output logic               cmd_wr,
  output itp_pkg::cmd_t      cmd
);

  logic skip;

  always_comb begin
    cmd.sym  = in_item.symbol;
    cmd.prec = itp_pkg::prec_of(in_item.symbol);
    skip     = 1'b0;
    priority if (in_item.end_of_expr) begin
      cmd.kind = itp_pkg::K_END;
    end else if (itp_pkg::is_space(in_item.symbol)) begin
      cmd.kind = itp_pkg::K_OPER;
      skip     = 1'b1;
    end else if (itp_pkg::is_operand(in_item.symbol)) begin
      cmd.kind = itp_pkg::K_OPND;
    end else if (in_item.symbol == itp_pkg::CH_OPEN) begin
      cmd.kind = itp_pkg::K_OPEN;
    end else if (in_item.symbol == itp_pkg::CH_CLOSE) begin
      cmd.kind = itp_pkg::K_CLOSE;
    end else begin
      cmd.kind = itp_pkg::K_OPER;
    end
  end

  // whitespace is taken and dropped here
  assign cmd_wr = push && !q_full && !skip;

endmodule

// ----- rtl/core/itp_back.sv -----
module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  itp_pkg::cmd_t       cmd,
  output logic                cmd_rd,
  input  logic                o_full,
  output logic                o_wr,
  output itp_pkg::out_item_t  o_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic {
    S_RUN,
    S_FLUSH
  } state_t;

  state_t             state_r, state_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               open_r, open_nxt;
  itp_pkg::out_item_t pend_r, pend_nxt;
  logic               pendv_r, pendv_nxt;

  logic [7:0]         mem [STACK_DEPTH];
  logic [7:0]         tos_r;
  logic [DW-1:0]      rd_full;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               we;

  logic               has_top;
  logic               top_open;
  logic               pop_emit;
  logic               push_op;
  logic               emit;
  logic               done;
  logic [7:0]         esym;
  logic [2:0]         est;

  assign has_top  = (depth_r != '0);
  assign top_open = (tos_r == itp_pkg::CH_OPEN);
  assign waddr    = depth_r[AW-1:0];
  assign rd_full  = depth_nxt - DW'(1);
  assign raddr    = rd_full[AW-1:0];

  // stack body, top entry kept in tos_r with write forwarding
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= cmd.sym;
    end
    if (we && (waddr == raddr)) begin
      tos_r <= cmd.sym;
    end else begin
      tos_r <= mem[raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    cnt_nxt   = cnt_r;
    open_nxt  = open_r;
    pend_nxt  = pend_r;
    pendv_nxt = pendv_r;
    cmd_rd    = 1'b0;
    o_wr      = 1'b0;
    o_data    = pend_r;
    o_data.last = 1'b0;
    we        = 1'b0;
    pop_emit  = 1'b0;
    push_op   = 1'b0;
    emit      = 1'b0;
    done      = 1'b0;
    esym      = itp_pkg::CH_NUL;
    est       = itp_pkg::ST_OK;

    unique case (state_r)
      S_FLUSH: begin
        if (!o_full) begin
          o_wr        = 1'b1;
          o_data.last = 1'b1;
          pendv_nxt   = 1'b0;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd_valid && !o_full) begin
          unique case (cmd.kind)
            itp_pkg::K_OPND: begin
              emit = 1'b1;
              esym = cmd.sym;
              if (cnt_r != 8'hFF) begin
                cnt_nxt = cnt_r + 8'd1;
              end
              done = 1'b1;
            end
            itp_pkg::K_OPEN: begin
              push_op = 1'b1;
              done    = 1'b1;
            end
            itp_pkg::K_CLOSE: begin
              if (has_top && !top_open) begin
                pop_emit = 1'b1;
              end else if (has_top) begin
                depth_nxt = depth_r - DW'(1);
                done      = 1'b1;
              end else begin
                emit = 1'b1;
                est  = itp_pkg::ST_UNMATCHED_CLOSE;
                done = 1'b1;
              end
            end
            itp_pkg::K_OPER: begin
              if (has_top && !top_open && (itp_pkg::prec_of(tos_r) >= cmd.prec)) begin
                pop_emit = 1'b1;
              end else begin
                push_op = 1'b1;
                done    = 1'b1;
              end
            end
            itp_pkg::K_END: begin
              if (has_top) begin
                if (top_open) begin
                  depth_nxt = depth_r - DW'(1);
                  open_nxt  = 1'b1;
                end else begin
                  pop_emit = 1'b1;
                end
              end else begin
                emit = 1'b1;
                if (open_r) begin
                  est = itp_pkg::ST_UNMATCHED_OPEN;
                end else if (cnt_r != 8'd1) begin
                  est = itp_pkg::ST_BAD_COUNT;
                end
                cnt_nxt  = 8'd0;
                open_nxt = 1'b0;
                done     = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase

          if (pop_emit) begin
            depth_nxt = depth_r - DW'(1);
            emit      = 1'b1;
            esym      = tos_r;
            if (cnt_r >= 8'd2) begin
              cnt_nxt = cnt_r - 8'd1;
            end else begin
              cnt_nxt = 8'd1;
              est     = itp_pkg::ST_MISSING_OPND;
            end
          end

          if (push_op) begin
            if (depth_r >= DW'(STACK_DEPTH)) begin
              emit = 1'b1;
              est  = itp_pkg::ST_OVERFLOW;
            end else begin
              we        = 1'b1;
              depth_nxt = depth_r + DW'(1);
            end
          end

          // the previous result of this item is not the final one
          if (emit) begin
            o_wr                = pendv_r;
            pend_nxt.out_symbol = esym;
            pend_nxt.status     = est;
            pend_nxt.last       = 1'b0;
            pendv_nxt           = 1'b1;
          end

          if (done) begin
            cmd_rd = 1'b1;
            if (emit || pendv_r) begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      depth_r <= '0;
      cnt_r   <= '0;
      open_r  <= 1'b0;
      pendv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      cnt_r   <= cnt_nxt;
      open_r  <= open_nxt;
      pendv_r <= pendv_nxt;
    end
    pend_r <= pend_nxt;
  end

endmodule

// ----- rtl/core/infix_to_postfix_converter.sv -----
// Infix to postfix converter.
// Input queue: drive in_item and raise push; the item is taken on a clock edge
// with push high and full low. end_of_expr closes an expression: the stack is
// flushed, a status result follows, and the stack and operand count clear.
// Result queue: while empty is low, out_item holds the oldest result; it is
// taken on an edge with pop high. last marks the final result of an item.
// Whitespace is taken and dropped in the front; other items go through a
// two-entry command queue to the stack engine, which handles one stack step
// per cycle while the result queue has room and writes results into a
// two-entry result queue. An operand item takes a run step that holds its
// result pending and a flush step that writes it out marked last; each
// operator popped adds a run step, as does each '(' dropped at end of
// expression. Stack entries sit in a memory with a registered top read.
// While the receiver does not pop, the result queue fills, the engine halts
// in place and full rises once the command queue is full. No item is lost.
// Reset (rst_n low, synchronous) empties both queues, the stack and the
// operand count; the stack memory needs no clearing.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  itp_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output itp_pkg::out_item_t out_item
);

  localparam int CW = $bits(itp_pkg::cmd_t);
  localparam int OW = $bits(itp_pkg::out_item_t);

  itp_pkg::cmd_t      f_cmd;
  logic               f_wr;
  logic [CW-1:0]      q_rdata;
  logic               q_empty;
  logic               q_rd;
  logic               o_full;
  logic               o_wr;
  itp_pkg::out_item_t o_data;
  logic [OW-1:0]      o_rdata;

  itp_front u_front (
    .push    (push),
    .in_item (in_item),
    .q_full  (full),
    .cmd_wr  (f_wr),
    .cmd     (f_cmd)
  );

  itp_fifo #(
    .WIDTH (CW),
    .DEPTH (itp_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (f_wr),
    .wdata (f_cmd),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (itp_pkg::cmd_t'(q_rdata)),
    .cmd_rd    (q_rd),
    .o_full    (o_full),
    .o_wr      (o_wr),
    .o_data    (o_data)
  );

  itp_fifo #(
    .WIDTH (OW),
    .DEPTH (itp_pkg::OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (o_wr),
    .wdata (o_data),
    .rd    (pop),
    .rdata (o_rdata),
    .full  (o_full),
    .empty (empty)
  );

  assign out_item = itp_pkg::out_item_t'(o_rdata);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int STK_DEPTH   = itp_pkg::STACK_DEPTH_DEF;
  localparam int RAND_ITEMS  = 420;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 400000;

  typedef enum int {GEN_WELL, GEN_BROKEN, GEN_NOISE, GEN_DEEP} gen_mode_t;

  typedef struct packed {
    itp_pkg::in_item_t  item;
    logic               typed;
    itp_pkg::out_item_t want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  logic               empty;
  logic               pop;
  itp_pkg::in_item_t  in_item;
  itp_pkg::out_item_t out_item;

  logic               drv_typed;
  itp_pkg::out_item_t drv_want;

  // predictor state
  logic [7:0]         op_stack [STK_DEPTH];
  int                 op_depth = 0;
  int                 opnd_cnt = 0;
  itp_pkg::out_item_t step_q[$];
  itp_pkg::out_item_t exp_q[$];
  itp_pkg::out_item_t want_r;

  row_t               dir_rows[$];
  itp_pkg::in_item_t  expr_q[$];
  itp_pkg::in_item_t  tmp_q[$];

  int        n_err = 0;
  int        n_in = 0;
  int        n_ends = 0;
  int        n_checked = 0;
  int        n_sent = 0;
  int        n_full_cycles = 0;
  int        cycle_cnt = 0;
  logic [7:0] stat_seen = '0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  infix_to_postfix_converter #(.STACK_DEPTH(STK_DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rank_of(input logic [7:0] ch);
    case (ch)
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return 1;
      itp_pkg::CH_STAR, itp_pkg::CH_SLASH: return 2;
      itp_pkg::CH_CARET:                   return 3;
      default:                             return 0;
    endcase
  endfunction

  function automatic bit letter_or_digit(input logic [7:0] ch);
    return (ch >= itp_pkg::CH_DIG0 && ch <= itp_pkg::CH_DIG9) ||
           (ch >= itp_pkg::CH_UPA && ch <= itp_pkg::CH_UPZ) ||
           (ch >= itp_pkg::CH_LOA && ch <= itp_pkg::CH_LOZ);
  endfunction

  function automatic bit blank(input logic [7:0] ch);
    return ch == itp_pkg::CH_SPACE || (ch >= itp_pkg::CH_TAB && ch <= itp_pkg::CH_CR);
  endfunction

  function automatic itp_pkg::in_item_t item_of(input logic [7:0] sym, input logic eoe);
    itp_pkg::in_item_t it;
    it.symbol      = sym;
    it.end_of_expr = eoe;
    return it;
  endfunction

  task automatic add_res(input logic [7:0] sym, input logic [2:0] st);
    itp_pkg::out_item_t r;
    r.out_symbol = sym;
    r.status     = st;
    r.last       = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic emit_top();
    logic [7:0] op;
    op_depth--;
    op = op_stack[op_depth];
    if (opnd_cnt >= 2) begin
      opnd_cnt--;
      add_res(op, itp_pkg::ST_OK);
    end else begin
      opnd_cnt = 1;
      add_res(op, itp_pkg::ST_MISSING_OPND);
    end
  endtask

  task automatic push_op(input logic [7:0] ch);
    if (op_depth >= STK_DEPTH) begin
      add_res(itp_pkg::CH_NUL, itp_pkg::ST_OVERFLOW);
    end else begin
      op_stack[op_depth] = ch;
      op_depth++;
    end
  endtask

  task automatic postfix_step(input itp_pkg::in_item_t it);
    logic [7:0]         ch;
    int                 r;
    bit                 open_left;
    itp_pkg::out_item_t tail;
    step_q.delete();
    ch = it.symbol;
    if (it.end_of_expr) begin
      open_left = 1'b0;
      while (op_depth > 0) begin
        if (op_stack[op_depth-1] == itp_pkg::CH_OPEN) begin
          op_depth--;
          open_left = 1'b1;
        end else begin
          emit_top();
        end
      end
      if (open_left) add_res(itp_pkg::CH_NUL, itp_pkg::ST_UNMATCHED_OPEN);
      else if (opnd_cnt != 1) add_res(itp_pkg::CH_NUL, itp_pkg::ST_BAD_COUNT);
      else add_res(itp_pkg::CH_NUL, itp_pkg::ST_OK);
      opnd_cnt = 0;
    end else if (blank(ch)) begin
    end else if (letter_or_digit(ch)) begin
      if (opnd_cnt < 255) opnd_cnt++;
      add_res(ch, itp_pkg::ST_OK);
    end else if (ch == itp_pkg::CH_OPEN) begin
      push_op(ch);
    end else if (ch == itp_pkg::CH_CLOSE) begin
      while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::CH_OPEN) emit_top();
      if (op_depth > 0) op_depth--;
      else add_res(itp_pkg::CH_NUL, itp_pkg::ST_UNMATCHED_CLOSE);
    end else begin
      r = rank_of(ch);
      while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::CH_OPEN &&
             rank_of(op_stack[op_depth-1]) >= r) emit_top();
      push_op(ch);
    end
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    n_err++;
    if (n_err <= 40) $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        n_in++;
        if (in_item.end_of_expr) n_ends++;
        postfix_step(in_item);
        if (drv_typed) exp_q.push_back(drv_want);
        else foreach (step_q[k]) exp_q.push_back(step_q[k]);
      end
      if (pop && !empty) begin
        n_checked++;
        stat_seen[out_item.status] = 1'b1;
        if (exp_q.size() == 0) begin
          report("item with nothing pending", 32'(out_item), 32'd0);
        end else begin
          want_r = exp_q.pop_front();
          if (out_item.out_symbol !== want_r.out_symbol)
            report("out_symbol", 32'(out_item.out_symbol), 32'(want_r.out_symbol));
          if (out_item.status !== want_r.status)
            report("status", 32'(out_item.status), 32'(want_r.status));
          if (out_item.last !== want_r.last)
            report("last", 32'(out_item.last), 32'(want_r.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (full) n_full_cycles++;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycle_cnt, exp_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side
  initial begin
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  task automatic add_row(input logic [7:0] sym, input logic eoe, input logic typed,
                         input logic [7:0] wsym, input logic [2:0] wst);
    row_t r;
    r.item            = item_of(sym, eoe);
    r.typed           = typed;
    r.want.out_symbol = wsym;
    r.want.status     = wst;
    r.want.last       = 1'b1;
    dir_rows.push_back(r);
  endtask

  task automatic send(input itp_pkg::in_item_t it, input logic typed,
                      input itp_pkg::out_item_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_item   <= it;
    drv_typed <= typed;
    drv_want  <= want;
    push      <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pause();
    push <= 1'b0;
    @(negedge clk);
    while (exp_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return itp_pkg::CH_DIG0 + 8'($urandom_range(0, 9));
      1:       return itp_pkg::CH_UPA + 8'($urandom_range(0, 25));
      default: return itp_pkg::CH_LOA + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_STAR;
      3:       return itp_pkg::CH_SLASH;
      default: return itp_pkg::CH_CARET;
    endcase
  endfunction

  task automatic put_sym(input logic [7:0] ch);
    int unsigned w;
    if ($urandom_range(0, 7) == 0) begin
      w = $urandom_range(8, 13);
      expr_q.push_back(item_of(w == 8 ? itp_pkg::CH_SPACE : 8'(w), 1'b0));
    end
    expr_q.push_back(item_of(ch, 1'b0));
  endtask

  task automatic gen_well();
    int nterms;
    int opens;
    nterms = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    opens = 0;
    for (int i = 0; i < nterms; i++) begin
      if (i > 0) put_sym(rand_op());
      while (opens < 6 && $urandom_range(0, 3) == 0) begin
        put_sym(itp_pkg::CH_OPEN);
        opens++;
      end
      put_sym(rand_operand());
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        put_sym(itp_pkg::CH_CLOSE);
        opens--;
      end
    end
    repeat (opens) put_sym(itp_pkg::CH_CLOSE);
  endtask

  task automatic gen_broken();
    int       k;
    bit       drop;
    logic [7:0] extra;
    gen_well();
    k = $urandom_range(0, expr_q.size() - 1);
    drop = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0:       extra = itp_pkg::CH_OPEN;
      1:       extra = itp_pkg::CH_CLOSE;
      2:       extra = rand_op();
      default: extra = 8'($urandom);
    endcase
    tmp_q.delete();
    foreach (expr_q[i]) begin
      if (i == k && !drop) tmp_q.push_back(item_of(extra, 1'b0));
      if (!(i == k && drop)) tmp_q.push_back(expr_q[i]);
    end
    expr_q = tmp_q;
  endtask

  task automatic gen_deep(input int n);
    repeat (n) put_sym(itp_pkg::CH_OPEN);
    put_sym(rand_operand());
    if ($urandom_range(0, 1) == 1) begin
      put_sym(rand_op());
      put_sym(rand_operand());
    end
    repeat (n + $urandom_range(0, 2)) put_sym(itp_pkg::CH_CLOSE);
  endtask

  initial begin
    int                 e;
    bit                 mid_done;
    gen_mode_t          mode;
    int unsigned        r;
    itp_pkg::out_item_t none;

    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    drv_typed = 1'b0;
    drv_want  = '0;
    none      = '0;
    e         = 0;
    mid_done  = 1'b0;

    add_row(itp_pkg::CH_NUL,   1'b1, 1'b1, itp_pkg::CH_NUL,  itp_pkg::ST_BAD_COUNT);
    add_row(itp_pkg::CH_LOA,   1'b0, 1'b1, itp_pkg::CH_LOA,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_PLUS,  1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_UPZ,   1'b0, 1'b1, itp_pkg::CH_UPZ,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_STAR,  1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_DIG9,  1'b0, 1'b1, itp_pkg::CH_DIG9, itp_pkg::ST_OK);
    add_row(itp_pkg::CH_CARET, 1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_DIG0,  1'b0, 1'b1, itp_pkg::CH_DIG0, itp_pkg::ST_OK);
    add_row(itp_pkg::CH_MINUS, 1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_TAB,   1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_LOZ,   1'b0, 1'b1, itp_pkg::CH_LOZ,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_NUL,   1'b1, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_CLOSE, 1'b0, 1'b1, itp_pkg::CH_NUL,  itp_pkg::ST_UNMATCHED_CLOSE);
    add_row(itp_pkg::CH_PLUS,  1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_PLUS,  1'b0, 1'b1, itp_pkg::CH_PLUS, itp_pkg::ST_MISSING_OPND);
    add_row(itp_pkg::CH_SPACE, 1'b1, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_OPEN,  1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_UPA,   1'b0, 1'b1, itp_pkg::CH_UPA,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_SLASH, 1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_NUL,   1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(8'hFF,             1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_CR,    1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(8'h0B,             1'b0, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(itp_pkg::CH_DIG0,  1'b1, 1'b0, itp_pkg::CH_NUL,  itp_pkg::ST_OK);
    add_row(8'hFF,             1'b1, 1'b1, itp_pkg::CH_NUL,  itp_pkg::ST_BAD_COUNT);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain_pause();

    while (n_sent < RAND_ITEMS) begin
      if (e == 1) hold_req = 1'b1;
      if (!mid_done && n_sent >= RAND_ITEMS / 2) begin
        drain_pause();
        mid_done = 1'b1;
      end
      quiet = (n_sent >= RAND_ITEMS - 60);
      r = $urandom_range(0, 19);
      if (e == 0) mode = GEN_DEEP;
      else if (r < 14) mode = GEN_WELL;
      else if (r < 16) mode = GEN_BROKEN;
      else if (r < 18) mode = GEN_NOISE;
      else mode = GEN_DEEP;

      expr_q.delete();
      case (mode)
        GEN_WELL:   gen_well();
        GEN_BROKEN: gen_broken();
        GEN_DEEP:   gen_deep(e == 0 ? STK_DEPTH + 2 : $urandom_range(24, 36));
        default: begin
          repeat ($urandom_range(1, 10))
            expr_q.push_back(item_of(8'($urandom), $urandom_range(0, 5) == 0));
        end
      endcase
      if (mode != GEN_NOISE) expr_q.push_back(item_of(8'($urandom), 1'b1));

      foreach (expr_q[i]) begin
        send(expr_q[i], 1'b0, none);
        if (expr_q[i].end_of_expr || !blank(expr_q[i].symbol)) n_sent++;
      end
      e++;
    end
    send(item_of(8'($urandom), 1'b1), 1'b0, none);

    push <= 1'b0;
    @(negedge clk);
    while (exp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d items accepted in %0d expressions, %0d results checked",
             n_in, n_ends, n_checked);
    $display("status codes returned (bit per code): %b, input stalled %0d cycles",
             stat_seen, n_full_cycles);
    if (n_err == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
